[sv/mbist_pkg.sv]
// Shared types and constants for the March memory BIST sequencer.
// Holds the configuration bundle, access codes and register map.
// Depends on nothing; every other file imports it.
package mbist_pkg;

    // Kind of memory access issued with each result transfer.
    typedef enum logic [1:0] {
        ACC_NONE  = 2'd0,
        ACC_READ  = 2'd1,
        ACC_WRITE = 2'd2
    } t_access_kind;

    // Input operation codes.
    localparam logic OP_START = 1'b0;
    localparam logic OP_NEXT  = 1'b1;

    // Register indexes on the configuration port (byte address = 4 * index).
    localparam logic [1:0] REG_BASE    = 2'd0;
    localparam logic [1:0] REG_COUNT   = 2'd1;
    localparam logic [1:0] REG_PATTERN = 2'd2;

    // Register reset values.
    localparam logic [31:0] RST_BASE    = 32'h0000_0000;
    localparam logic [31:0] RST_COUNT   = 32'd1024;
    localparam logic [31:0] RST_PATTERN = 32'h5555_5555;

    // Current configuration as seen by the sequencer.
    typedef struct packed {
        logic [31:0] base_address;
        logic [31:0] word_count;
        logic [31:0] background_pattern;
    } t_cfg;

endpackage

[sv/mbist_regs.sv]
// Configuration register file of the March BIST sequencer, on an APB-style port.
// Depends on mbist_pkg for the register map, reset values and the t_cfg bundle.
module mbist_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mbist_pkg::t_cfg   o_cfg
);
    import mbist_pkg::*;

    logic [31:0] r_base;
    logic [31:0] r_count;
    logic [31:0] r_pattern;
    logic        wr_en;
    logic [1:0]  reg_idx;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    // Register writes in the access phase of a write transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base    <= RST_BASE;
            r_count   <= RST_COUNT;
            r_pattern <= RST_PATTERN;
        end else if (wr_en) begin
            case (reg_idx)
                REG_BASE:    r_base    <= pwdata;
                REG_COUNT:   r_count   <= pwdata;
                REG_PATTERN: r_pattern <= pwdata;
                default: ;
            endcase
        end
    end

    // Read data; unmapped addresses read as zero.
    always_comb begin
        case (reg_idx)
            REG_BASE:    prdata = r_base;
            REG_COUNT:   prdata = r_count;
            REG_PATTERN: prdata = r_pattern;
            default:     prdata = 32'h0;
        endcase
    end

    assign o_cfg.base_address       = r_base;
    assign o_cfg.word_count         = r_count;
    assign o_cfg.background_pattern = r_pattern;

endmodule

[sv/mbist_seq.sv]
// March test sequencer: input register, next-access logic and result register.
// Depends on mbist_pkg for access codes, operation codes and the t_cfg bundle.
module mbist_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mbist_pkg::t_cfg   i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_op,
    input  logic [31:0]       i_read_value,
    input  logic              i_access_ok,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_access_kind,
    output logic [31:0]       o_mem_address,
    output logic [31:0]       o_write_value,
    output logic              o_done_res,
    output logic              o_passed
);
    import mbist_pkg::*;

    // March elements; ELEM_DONE marks a finished or aborted test.
    typedef enum logic [2:0] {
        ELEM_W_X_DN  = 3'd0,
        ELEM_UP_X_Y  = 3'd1,
        ELEM_UP_Y_X  = 3'd2,
        ELEM_DN_X_Y  = 3'd3,
        ELEM_DN_Y_X  = 3'd4,
        ELEM_DONE    = 3'd5
    } t_elem;

    // Input register.
    logic         r_in_valid;
    logic         r_op;
    logic [31:0]  r_rd;
    logic         r_ok;

    // Sequencer state.
    logic         r_running;
    t_elem        r_elem;
    logic [1:0]   r_step;
    logic [31:0]  r_addr;
    logic [31:0]  r_exp;
    logic         r_pend;
    logic         r_fail;

    // Result register.
    logic         r_out_valid;
    t_access_kind r_kind;
    logic [31:0]  r_maddr;
    logic [31:0]  r_wval;
    logic         r_done;
    logic         r_pass;

    // Next values.
    logic         n_running;
    t_elem        n_elem;
    logic [1:0]   n_step;
    logic [31:0]  n_addr;
    logic [31:0]  n_exp;
    logic         n_pend;
    logic         n_fail;
    t_access_kind n_kind;
    logic [31:0]  n_maddr;
    logic [31:0]  n_wval;
    logic         n_done;
    logic         n_pass;

    logic         proc;
    logic         issue;
    logic [31:0]  last_addr;
    logic         desc;
    logic [31:0]  loop_end;
    logic [31:0]  pat_x;
    logic [31:0]  pat_y;
    logic [31:0]  first_val;
    logic [31:0]  second_val;

    function automatic t_elem elem_after(input t_elem e);
        case (e)
            ELEM_W_X_DN: elem_after = ELEM_UP_X_Y;
            ELEM_UP_X_Y: elem_after = ELEM_UP_Y_X;
            ELEM_UP_Y_X: elem_after = ELEM_DN_X_Y;
            ELEM_DN_X_Y: elem_after = ELEM_DN_Y_X;
            default:     elem_after = ELEM_DONE;
        endcase
    endfunction

    function automatic logic elem_desc(input t_elem e);
        elem_desc = (e == ELEM_W_X_DN) || (e == ELEM_DN_X_Y) || (e == ELEM_DN_Y_X);
    endfunction

    // The buffered item moves on when the result register is free or being drained.
    assign proc    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || proc;

    assign last_addr = i_cfg.base_address + i_cfg.word_count - 32'd1;
    assign desc      = elem_desc(r_elem);
    assign loop_end  = desc ? i_cfg.base_address : last_addr;
    assign pat_x     = i_cfg.background_pattern;
    assign pat_y     = ~i_cfg.background_pattern;

    // Step the march sequence by one access, then select the access to issue.
    always_comb begin
        n_running = r_running;
        n_elem    = r_elem;
        n_step    = r_step;
        n_addr    = r_addr;
        n_exp     = r_exp;
        n_pend    = r_pend;
        n_fail    = r_fail;
        issue     = 1'b0;
        n_done    = 1'b0;
        n_pass    = 1'b0;

        if (r_op == OP_START) begin
            n_running = 1'b1;
            n_fail    = 1'b0;
            n_elem    = ELEM_W_X_DN;
            n_step    = 2'd0;
            n_addr    = last_addr;
            issue     = 1'b1;
        end else if (!r_running) begin
            n_done = (r_elem == ELEM_DONE);
            n_pass = (r_elem == ELEM_DONE) && !r_fail;
        end else if (!r_ok || (r_pend && (r_rd != r_exp))) begin
            n_running = 1'b0;
            n_fail    = 1'b1;
            n_pend    = 1'b0;
            n_elem    = ELEM_DONE;
            n_done    = 1'b1;
        end else if ((r_elem != ELEM_W_X_DN) && (r_step < 2'd2)) begin
            n_step = r_step + 2'd1;
            issue  = 1'b1;
        end else begin
            n_step = 2'd0;
            if (r_addr != loop_end) begin
                n_addr = desc ? (r_addr - 32'd1) : (r_addr + 32'd1);
                issue  = 1'b1;
            end else if (r_elem == ELEM_DN_Y_X) begin
                // Last element finished without fault.
                n_running = 1'b0;
                n_pend    = 1'b0;
                n_elem    = ELEM_DONE;
                n_done    = 1'b1;
                n_pass    = 1'b1;
            end else begin
                n_elem = elem_after(r_elem);
                n_addr = elem_desc(elem_after(r_elem)) ? last_addr : i_cfg.base_address;
                issue  = 1'b1;
            end
        end

        // Access selection from the new element, micro step and address.
        first_val  = ((n_elem == ELEM_UP_X_Y) || (n_elem == ELEM_DN_X_Y)) ? pat_x : pat_y;
        second_val = ((n_elem == ELEM_UP_X_Y) || (n_elem == ELEM_DN_X_Y)) ? pat_y : pat_x;
        n_kind     = ACC_NONE;
        n_maddr    = 32'h0;
        n_wval     = 32'h0;
        if (issue) begin
            n_maddr = n_addr;
            if (n_elem == ELEM_W_X_DN) begin
                n_kind = ACC_WRITE;
                n_wval = pat_x;
                n_pend = 1'b0;
            end else if (n_step == 2'd1) begin
                n_kind = ACC_WRITE;
                n_wval = second_val;
                n_pend = 1'b0;
            end else begin
                n_kind = ACC_READ;
                n_exp  = (n_step == 2'd0) ? first_val : second_val;
                n_pend = 1'b1;
            end
        end
    end

    // Input register: holds one item until the result side can take it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op <= i_op;
            r_rd <= i_read_value;
            r_ok <= i_access_ok;
        end
    end

    // Sequencer state, result valid and result payload.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_elem      <= ELEM_W_X_DN;
            r_step      <= 2'd0;
            r_addr      <= 32'h0;
            r_exp       <= 32'h0;
            r_pend      <= 1'b0;
            r_fail      <= 1'b0;
            r_out_valid <= 1'b0;
            r_kind      <= ACC_NONE;
            r_maddr     <= 32'h0;
            r_wval      <= 32'h0;
            r_done      <= 1'b0;
            r_pass      <= 1'b0;
        end else if (proc) begin
            r_running   <= n_running;
            r_elem      <= n_elem;
            r_step      <= n_step;
            r_addr      <= n_addr;
            r_exp       <= n_exp;
            r_pend      <= n_pend;
            r_fail      <= n_fail;
            r_out_valid <= 1'b1;
            r_kind      <= n_kind;
            r_maddr     <= n_maddr;
            r_wval      <= n_wval;
            r_done      <= n_done;
            r_pass      <= n_pass;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_access_kind = r_kind;
    assign o_mem_address = r_maddr;
    assign o_write_value = r_wval;
    assign o_done_res    = r_done;
    assign o_passed      = r_pass;

    // A pending read only exists inside a running test.
    a_pend_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_running)
        else $error("read pending while sequencer is not running");

    // A running test never sits in the finished marker.
    a_running_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_elem != ELEM_DONE))
        else $error("running with finished element marker");

    // A start always answers with a write.
    a_start_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && (r_op == OP_START)) |=> (r_kind == ACC_WRITE))
        else $error("start did not issue a write");

    // Idle results carry zero address and data.
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_kind == ACC_NONE)) |-> ((r_maddr == 32'h0) && (r_wval == 32'h0)))
        else $error("idle result with nonzero address or data");

    // Done is only reported with no access.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (r_kind == ACC_NONE))
        else $error("done reported together with an access");

endmodule

[sv/march_memory_bist_sequencer.sv]
// March memory BIST sequencer: one accepted transfer in, one memory access out.
// An accepted transfer is registered in the input register; its result is then registered
// in the result register once that is free or drained; next-access logic is combinational.
// Throughput: one transfer per cycle while the result side does not stall.
// Reset (synchronous, active low) clears the sequencer to idle and loads register defaults.
module march_memory_bist_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_op,
    input  logic [31:0] i_read_value,
    input  logic        i_access_ok,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_access_kind,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_write_value,
    output logic        o_done_res,
    output logic        o_passed
);
    import mbist_pkg::*;

    t_cfg cfg;

    // Configuration registers.
    mbist_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Sequencer datapath.
    mbist_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_read_value  (i_read_value),
        .i_access_ok   (i_access_ok),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_access_kind (o_access_kind),
        .o_mem_address (o_mem_address),
        .o_write_value (o_write_value),
        .o_done_res    (o_done_res),
        .o_passed      (o_passed)
    );

endmodule

[tb/sv/march_memory_bist_sequencer_tb.sv]
// Self-checking testbench for the March memory BIST sequencer.
// Depends on mbist_pkg and march_memory_bist_sequencer; a built-in memory image
// answers the issued accesses so that most transfers walk complete March tests.
module march_memory_bist_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mbist_pkg::*;

    // March elements in order; EL_DONE marks a finished or aborted test.
    typedef enum logic [2:0] {
        EL_FILL     = 3'd0,
        EL_UP_XY    = 3'd1,
        EL_UP_YX    = 3'd2,
        EL_DOWN_XY  = 3'd3,
        EL_DOWN_YX  = 3'd4,
        EL_DONE     = 3'd5
    } t_march_elem;

    // Position inside a read-write-read element.
    localparam logic [1:0] STEP_FIRST_RD = 2'd0;
    localparam logic [1:0] STEP_WR       = 2'd1;
    localparam logic [1:0] STEP_LAST_RD  = 2'd2;

    typedef struct packed {
        t_access_kind kind;
        logic [31:0]  addr;
        logic [31:0]  wdata;
        logic         done;
        logic         passed;
    } t_mem_access;

    typedef enum logic {ROW_XFER, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [1:0]  idx;
        logic        op;
        logic [31:0] rv;
        logic        ok;
        logic        fixed;
        t_mem_access exp;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_op = OP_NEXT;
    logic [31:0] i_read_value = '0;
    logic        i_access_ok = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_access_kind;
    logic [31:0] o_mem_address;
    logic [31:0] o_write_value;
    logic        o_done_res;
    logic        o_passed;

    march_memory_bist_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_read_value  (i_read_value),
        .i_access_ok   (i_access_ok),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_access_kind (o_access_kind),
        .o_mem_address (o_mem_address),
        .o_write_value (o_write_value),
        .o_done_res    (o_done_res),
        .o_passed      (o_passed)
    );

    // Clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predictor copy of the registers and the sequencer state.
    t_cfg        bist_cfg = '{RST_BASE, RST_COUNT, RST_PATTERN};
    logic        seq_running = 1'b0;
    t_march_elem seq_elem = EL_FILL;
    logic [1:0]  seq_step = STEP_FIRST_RD;
    logic [31:0] seq_addr = '0;
    logic [31:0] seq_expect = '0;
    logic        seq_rd_pend = 1'b0;
    logic        seq_fail = 1'b0;

    // Accesses predicted but not yet seen on the result side.
    t_mem_access expected_accesses[$];
    t_mem_access predicted;
    t_mem_access want;

    // Memory behind the BIST, filled by the predicted writes.
    logic [31:0]  mem_image [bit [31:0]];
    t_access_kind prev_kind = ACC_NONE;
    logic [31:0]  prev_addr = '0;

    // Directed rows may carry a typed expectation instead of the prediction.
    logic        use_fixed = 1'b0;
    t_mem_access fixed_access = '0;

    int unsigned rx_hold = 0;
    logic        quiet = 1'b0;
    int          errors = 0;

    function automatic logic [31:0] top_addr();
        return bist_cfg.base_address + bist_cfg.word_count - 32'd1;
    endfunction

    function automatic logic descending(t_march_elem e);
        return e == EL_FILL || e == EL_DOWN_XY || e == EL_DOWN_YX;
    endfunction

    function automatic t_mem_access idle_access(logic done, logic ok);
        t_mem_access r;
        r = '0;
        r.kind = ACC_NONE;
        r.done = done;
        r.passed = ok;
        return r;
    endfunction

    // Build the access selected by the current element, step and address.
    function automatic t_mem_access issue_access();
        t_mem_access r;
        logic [31:0] x;
        logic [31:0] first;
        logic [31:0] second;
        x = bist_cfg.background_pattern;
        first = (seq_elem == EL_UP_XY || seq_elem == EL_DOWN_XY) ? x : ~x;
        second = ~first;
        r = '0;
        r.addr = seq_addr;
        if (seq_elem == EL_FILL) begin
            r.kind = ACC_WRITE;
            r.wdata = x;
            seq_rd_pend = 1'b0;
        end else if (seq_step == STEP_WR) begin
            r.kind = ACC_WRITE;
            r.wdata = second;
            seq_rd_pend = 1'b0;
        end else begin
            r.kind = ACC_READ;
            seq_expect = (seq_step == STEP_FIRST_RD) ? first : second;
            seq_rd_pend = 1'b1;
        end
        return r;
    endfunction

    // Advance the March sequence by one input transfer.
    function automatic t_mem_access march_step(logic op, logic [31:0] rv, logic ok);
        logic desc;
        logic [31:0] stop_addr;
        if (op == OP_START) begin
            seq_running = 1'b1;
            seq_fail = 1'b0;
            seq_elem = EL_FILL;
            seq_step = STEP_FIRST_RD;
            seq_addr = top_addr();
            return issue_access();
        end
        if (!seq_running)
            return idle_access(seq_elem == EL_DONE, seq_elem == EL_DONE && !seq_fail);
        // A failed access or a read mismatch ends the test at once.
        if (!ok || (seq_rd_pend && rv != seq_expect)) begin
            seq_running = 1'b0;
            seq_fail = 1'b1;
            seq_rd_pend = 1'b0;
            seq_elem = EL_DONE;
            return idle_access(1'b1, 1'b0);
        end
        if (seq_elem != EL_FILL && seq_step < STEP_LAST_RD) begin
            seq_step = seq_step + 2'd1;
        end else begin
            desc = descending(seq_elem);
            stop_addr = desc ? bist_cfg.base_address : top_addr();
            seq_step = STEP_FIRST_RD;
            if (seq_addr != stop_addr) begin
                seq_addr = desc ? seq_addr - 32'd1 : seq_addr + 32'd1;
            end else if (seq_elem >= EL_DOWN_YX) begin
                seq_running = 1'b0;
                seq_rd_pend = 1'b0;
                seq_elem = EL_DONE;
                return idle_access(1'b1, 1'b1);
            end else begin
                seq_elem = t_march_elem'(seq_elem + 3'd1);
                seq_addr = descending(seq_elem) ? top_addr() : bist_cfg.base_address;
            end
        end
        return issue_access();
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got);
        if (exp_v !== got) begin
            $error("%s: expected %h, got %h", name, exp_v, got);
            errors++;
        end
    endfunction

    // Predict on each input transfer, check each result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                predicted = march_step(i_op, i_read_value, i_access_ok);
                if (predicted.kind == ACC_WRITE)
                    mem_image[predicted.addr] = predicted.wdata;
                prev_kind = predicted.kind;
                prev_addr = predicted.addr;
                expected_accesses.push_back(use_fixed ? fixed_access : predicted);
            end
            if (o_valid && i_ready) begin
                if (expected_accesses.size() == 0) begin
                    $error("result transfer with no access expected");
                    errors++;
                end else begin
                    want = expected_accesses.pop_front();
                    check_field("access_kind", 32'(want.kind), 32'(o_access_kind));
                    check_field("mem_address", want.addr, o_mem_address);
                    check_field("write_value", want.wdata, o_write_value);
                    check_field("done_res", 32'(want.done), 32'(o_done_res));
                    check_field("passed", 32'(want.passed), 32'(o_passed));
                end
            end
        end
    end

    // Result side: random stalls per transfer, plus an optional long hold-off.
    initial begin
        int unsigned n;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_ready = 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end else if (!quiet) begin
                n = $urandom_range(0, 15);
                if (n > 0) begin
                    i_ready = 1'b0;
                    repeat (n) @(negedge i_clk);
                end
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Register write over the configuration port; called at a falling edge.
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_BASE:    bist_cfg.base_address = val;
            REG_COUNT:   bist_cfg.word_count = val;
            REG_PATTERN: bist_cfg.background_pattern = val;
            default: ;
        endcase
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // Offer one input transfer after a gap; returns at the falling edge after acceptance.
    task automatic send_item(logic op, logic [31:0] rv, logic ok, int unsigned gap);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_op = op;
        i_read_value = rv;
        i_access_ok = ok;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Stop offering and wait until every expected access has come back.
    task automatic settle();
        i_valid = 1'b0;
        while (expected_accesses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic t_stim_row xfer(logic op, logic [31:0] rv, logic ok);
        t_stim_row r;
        r.kind = ROW_XFER;
        r.idx = REG_BASE;
        r.op = op;
        r.rv = rv;
        r.ok = ok;
        r.fixed = 1'b0;
        r.exp = '0;
        return r;
    endfunction

    function automatic t_stim_row xfer_exp(logic op, logic [31:0] rv, logic ok,
                                           t_access_kind k, logic [31:0] a,
                                           logic [31:0] w, logic d, logic p);
        t_stim_row r;
        r = xfer(op, rv, ok);
        r.fixed = 1'b1;
        r.exp.kind = k;
        r.exp.addr = a;
        r.exp.wdata = w;
        r.exp.done = d;
        r.exp.passed = p;
        return r;
    endfunction

    function automatic t_stim_row reg_row(logic [1:0] idx, logic [31:0] val);
        t_stim_row r;
        r = xfer(OP_NEXT, val, 1'b0);
        r.kind = ROW_CFG;
        r.idx = idx;
        return r;
    endfunction

    // Main stimulus: directed table, then random phases.
    initial begin
        t_stim_row   directed[$];
        t_stim_row   row;
        int          sent;
        int          phase;
        int          plen;
        int          k;
        int unsigned pick;
        logic        op_v;
        logic [31:0] rv_v;
        logic        ok_v;
        logic [31:0] v;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Idle after reset, then a start with the default registers.
        directed.push_back(xfer_exp(OP_NEXT, '1, 1'b0, ACC_NONE, '0, '0, 1'b0, 1'b0));
        directed.push_back(xfer_exp(OP_START, '1, 1'b0, ACC_WRITE, 32'h3FF, RST_PATTERN,
                                    1'b0, 1'b0));
        // A failed write aborts; afterwards the block reports done without pass.
        directed.push_back(xfer_exp(OP_NEXT, '0, 1'b0, ACC_NONE, '0, '0, 1'b1, 1'b0));
        directed.push_back(xfer_exp(OP_NEXT, '0, 1'b1, ACC_NONE, '0, '0, 1'b1, 1'b0));
        // One word at the top of the address space with an all-zero background.
        directed.push_back(reg_row(REG_BASE, 32'hFFFF_FFFF));
        directed.push_back(reg_row(REG_COUNT, 32'd1));
        directed.push_back(reg_row(REG_PATTERN, 32'h0));
        directed.push_back(xfer_exp(OP_START, '0, 1'b1, ACC_WRITE, 32'hFFFF_FFFF, '0,
                                    1'b0, 1'b0));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer(OP_NEXT, '1, 1'b1));
        directed.push_back(xfer(OP_NEXT, '1, 1'b1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer(OP_NEXT, '1, 1'b1));
        directed.push_back(xfer(OP_NEXT, '1, 1'b1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer_exp(OP_NEXT, '0, 1'b1, ACC_NONE, '0, '0, 1'b1, 1'b1));
        directed.push_back(xfer_exp(OP_NEXT, '1, 1'b0, ACC_NONE, '0, '0, 1'b1, 1'b1));
        // Zero word count covers the whole space; the count changes mid-test.
        directed.push_back(reg_row(REG_PATTERN, 32'hFFFF_FFFF));
        directed.push_back(reg_row(REG_BASE, 32'h10));
        directed.push_back(reg_row(REG_COUNT, 32'd0));
        directed.push_back(xfer_exp(OP_START, '0, 1'b1, ACC_WRITE, 32'hF, 32'hFFFF_FFFF,
                                    1'b0, 1'b0));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(reg_row(REG_COUNT, 32'd1));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        // Restart in the middle of a test, then a read mismatch aborts.
        directed.push_back(xfer(OP_START, '1, 1'b0));
        directed.push_back(xfer(OP_NEXT, '0, 1'b1));
        directed.push_back(xfer_exp(OP_NEXT, '0, 1'b1, ACC_NONE, '0, '0, 1'b1, 1'b0));

        foreach (directed[i]) begin
            row = directed[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_reg(row.idx, row.rv);
            end else begin
                use_fixed = row.fixed;
                fixed_access = row.exp;
                send_item(row.op, row.rv, row.ok, $urandom_range(0, 15));
            end
        end
        use_fixed = 1'b0;

        // Random phases: new registers, then mostly well-formed March traffic.
        sent = 0;
        phase = 0;
        while (sent < 650) begin
            settle();
            quiet = (phase % 4 == 3);
            if (phase == 0 || $urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0;
                    1: v = 32'hFFFF_FFFF;
                    2: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: v = $urandom;
                endcase
                write_reg(REG_BASE, v);
            end
            if (phase == 0 || $urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 19))
                    0: v = 32'h0;
                    1: v = 32'hFFFF_FFFF;
                    2: v = $urandom;
                    default: v = $urandom_range(1, 3);
                endcase
                write_reg(REG_COUNT, v);
            end
            if (phase == 0 || $urandom_range(0, 9) < 6) begin
                case ($urandom_range(0, 5))
                    0: v = 32'h0;
                    1: v = 32'hFFFF_FFFF;
                    default: v = $urandom;
                endcase
                write_reg(REG_PATTERN, v);
            end
            // Long result-side hold-off so the block backs up into its input.
            if (phase == 2)
                rx_hold = 300;
            plen = $urandom_range(15, 60);
            for (k = 0; k < plen; k++) begin
                // Sender pause until all outstanding results have drained.
                if (phase == 4 && k == 8)
                    settle();
                pick = $urandom_range(0, 99);
                op_v = OP_NEXT;
                ok_v = 1'b1;
                if (prev_kind == ACC_READ && mem_image.exists(prev_addr))
                    rv_v = mem_image[prev_addr];
                else
                    rv_v = $urandom;
                if ((k == 0 && pick < 80) || (!seq_running && pick < 60) || pick < 3) begin
                    op_v = OP_START;
                    rv_v = $urandom;
                    ok_v = 1'($urandom_range(0, 1));
                end else if (pick < 5) begin
                    rv_v = $urandom;
                    ok_v = 1'($urandom_range(0, 1));
                end else if (pick < 6) begin
                    ok_v = 1'b0;
                end else if (pick < 7) begin
                    rv_v = rv_v ^ (32'd1 << $urandom_range(0, 31));
                end
                send_item(op_v, rv_v, ok_v, quiet ? 0 : $urandom_range(0, 15));
                sent++;
            end
            i_valid = 1'b0;
            phase++;
        end

        // Drain what is still outstanding, then allow for the pipeline latency.
        i_valid = 1'b0;
        for (k = 0; k < 4000 && expected_accesses.size() != 0; k++)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (expected_accesses.size() != 0) begin
            $error("%0d expected accesses never arrived", expected_accesses.size());
            errors++;
        end
        if (errors == 0)
            $display("march_memory_bist_sequencer_tb OK");
        else
            $display("march_memory_bist_sequencer_tb NOT OK");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5_000_000;
        $display("march_memory_bist_sequencer_tb NOT OK");
        $finish;
    end

endmodule
